>>> rtl/core/wlv_pkg.sv
// Shared types, codes and reset constants for the wake line validator.
// No dependencies; every other file of the block imports this package.
package wlv_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned LevelW  = 10;
  localparam int unsigned TimerW  = 8;
  localparam int unsigned CountW  = 16;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned SamplesAveragedDef = 3;

  localparam logic [CfgW-1:0] ValidationTicksRst = 8'd15;
  localparam logic [CfgW-1:0] BatteryLowRst      = 8'd60;
  localparam logic [CfgW-1:0] BatteryHighRst     = 8'd160;
  localparam logic [CfgW-1:0] CircuitMinRiseRst  = 8'd20;

  localparam logic [CountW-1:0] CountMax = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_TICK        = 2'd0,
    OP_DETECT_ONE  = 2'd1,
    OP_DETECT_TWO  = 2'd2,
    OP_SLEEP_RESET = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_OFF   = 2'd2,
    PH_ON    = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VALIDATION_TICKS = 2'd0,
    CFG_BATTERY_LOW      = 2'd1,
    CFG_BATTERY_HIGH     = 2'd2,
    CFG_CIRCUIT_MIN_RISE = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SRC_NONE     = 2'd0,
    SRC_LINE_ONE = 2'd1,
    SRC_LINE_TWO = 2'd2
  } source_e;

  typedef struct packed {
    op_e                operation;
    logic [SampleW-1:0] adc_sample;
    logic               line_one_level;
    logic               line_two_level;
    logic               in_standby;
    logic               host_condition;
  } in_item_t;

  typedef struct packed {
    logic               filter_enable;
    logic               sample_taken;
    logic               line_one_confirmed;
    logic               line_two_confirmed;
    logic               standby_request;
    logic               circuit_fault;
    logic [1:0]         first_source;
    logic [CountW-1:0]  line_one_good_count;
    logic [CountW-1:0]  line_two_good_count;
  } out_item_t;

  // Status of the battery measurement, next values where the result needs them.
  typedef struct packed {
    phase_e            phase;
    logic              filter_pin;
    logic              filter_d;
    logic              taken;
    logic              fault_d;
    logic [LevelW-1:0] on_level_d;
  } meas_stat_t;

  typedef struct packed {
    logic confirmed;
    logic failed;
  } judge_t;

endpackage

>>> rtl/core/wlv_measure.sv
// Battery measurement sequencer: filter-off and filter-on averaging and the
// circuit fault diagnosis. Depends on wlv_pkg.
module wlv_measure import wlv_pkg::*; #(
  parameter int unsigned SAMPLES_AVERAGED = SamplesAveragedDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tick_i,
  input  logic               restart_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic [CfgW-1:0]    min_rise_i,
  output meas_stat_t         stat_o
);

  // Division by the sample count as a multiply by a rounded-up reciprocal.
  // It is exact for every level below 2**LevelW at counts of one to three.
  localparam int unsigned DivShift = LevelW + 1;
  localparam int unsigned RecipW   = DivShift + 1;
  localparam logic [RecipW-1:0] Recip =
    RecipW'((2 ** DivShift + SAMPLES_AVERAGED - 1) / SAMPLES_AVERAGED);
  localparam logic [1:0] CountLast = 2'(SAMPLES_AVERAGED);

  phase_e            phase_q, phase_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [LevelW-1:0] off_q, off_d;
  logic [LevelW-1:0] on_q, on_d;
  logic              fault_q, fault_d;
  logic              filter_q, filter_d;

  logic [LevelW-1:0]        off_sum, on_sum, div_in, quot;
  logic [LevelW+RecipW-1:0] prod;
  logic [1:0]               cnt_inc;
  logic                     done;
  logic signed [LevelW+1:0] rise;

  assign off_sum = off_q + LevelW'(sample_i);
  assign on_sum  = on_q + LevelW'(sample_i);
  assign cnt_inc = cnt_q + 2'd1;
  assign done    = (cnt_inc >= CountLast);
  assign div_in  = (phase_q == PH_ON) ? on_sum : off_sum;
  assign prod    = (LevelW + RecipW)'(div_in) * (LevelW + RecipW)'(Recip);
  assign quot    = prod[DivShift +: LevelW];
  assign rise    = $signed({2'b00, quot}) - $signed({2'b00, off_q});

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (restart_i) begin
      phase_d = PH_START;
    end else if (tick_i) begin
      unique case (phase_q)
        PH_START: phase_d = PH_OFF;
        PH_OFF:   phase_d = done ? PH_ON : PH_OFF;
        PH_ON:    phase_d = done ? PH_IDLE : PH_ON;
        default:  phase_d = phase_q;
      endcase
    end
  end

  // Datapath and outputs of the sequencer.
  always_comb begin
    cnt_d    = cnt_q;
    off_d    = off_q;
    on_d     = on_q;
    fault_d  = fault_q;
    filter_d = filter_q;
    stat_o.taken = 1'b0;
    if (restart_i) begin
      off_d = '0;
      on_d  = '0;
    end else if (tick_i) begin
      unique case (phase_q)
        PH_START: begin
          cnt_d    = '0;
          filter_d = 1'b0;
        end
        PH_OFF: begin
          stat_o.taken = 1'b1;
          cnt_d = cnt_inc;
          off_d = off_sum;
          if (done) begin
            cnt_d    = '0;
            filter_d = 1'b1;
            off_d    = quot;
          end
        end
        PH_ON: begin
          stat_o.taken = 1'b1;
          cnt_d = cnt_inc;
          on_d  = on_sum;
          if (done) begin
            cnt_d    = '0;
            filter_d = 1'b0;
            on_d     = quot;
            fault_d  = (rise < $signed({4'b0000, min_rise_i}));
          end
        end
        default: begin
        end
      endcase
    end
    stat_o.phase      = phase_q;
    stat_o.filter_pin = filter_q;
    stat_o.filter_d   = filter_d;
    stat_o.fault_d    = fault_d;
    stat_o.on_level_d = on_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      cnt_q    <= '0;
      off_q    <= '0;
      on_q     <= '0;
      fault_q  <= 1'b0;
      filter_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      off_q    <= off_d;
      on_q     <= on_d;
      fault_q  <= fault_d;
      filter_q <= filter_d;
    end
  end

endmodule

>>> rtl/core/wlv_line_judge.sv
// Validation timer and saturating good-pulse counter of one wake line.
// Depends on wlv_pkg.
module wlv_line_judge import wlv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [TimerW-1:0] ticks_i,
  input  logic              step_i,
  input  logic              level_i,
  input  logic              cond_i,
  output judge_t            judge_o,
  output logic [CountW-1:0] count_d_o
);

  logic [TimerW-1:0] timer_q, timer_d;
  logic [CountW-1:0] count_q, count_d;
  logic              last;

  // The line is judged on the tick that takes its timer from one to zero.
  assign last = step_i && (timer_q == TimerW'(1));

  always_comb begin
    timer_d = timer_q;
    count_d = count_q;
    judge_o.confirmed = last && !level_i && cond_i;
    judge_o.failed    = last && !judge_o.confirmed;
    if (load_i) begin
      timer_d = ticks_i;
    end else if (step_i && (timer_q != '0)) begin
      timer_d = timer_q - TimerW'(1);
    end
    if (judge_o.confirmed && (count_q != CountMax)) begin
      count_d = count_q + CountW'(1);
    end
  end

  assign count_d_o = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q <= '0;
      count_q <= '0;
    end else begin
      timer_q <= timer_d;
      count_q <= count_d;
    end
  end

endmodule

>>> rtl/core/wlv_out_buf.sv
// Result register with a skid stage, so input ready never depends on output
// ready combinationally. Depends on wlv_pkg.
module wlv_out_buf import wlv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t data_i,
  output logic      ready_o,
  output logic      valid_o,
  input  logic      ready_i,
  output out_item_t data_o
);

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t out_q, out_d;
  out_item_t skid_q, skid_d;

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || ready_i) begin
      // The result register frees up: it takes the parked beat first.
      out_valid_d  = skid_valid_q || push_i;
      out_d        = skid_valid_q ? skid_q : data_i;
      skid_valid_d = 1'b0;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

>>> rtl/core/wake_line_validator.sv
// Wake line validator top level: configuration registers, condition logic,
// first-source latch. Depends on wlv_pkg, wlv_measure, wlv_line_judge, wlv_out_buf.
//
// Usage: each input beat on in_item_i (valid/ready) is one event: a tick, a
// detect on line one or two, or a sleep reset of the battery measurement.
// Every accepted beat yields exactly one result beat on out_item_o
// (valid/ready), in order. The whole update of the measurement, the line
// timers, the counters and the first-source latch happens in the cycle the
// beat is accepted; the result is registered in the result or skid register.
// Throughput is one beat per cycle while the receiver does not stall.
// When the receiver stalls, one more beat is taken into a skid register and
// in_ready_o then drops until the result register drains.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i with no
// read-back; the user must write them only while no beat is in flight (unchecked).
// Reset (rst_ni low, asynchronous) restores the register defaults, stops the
// measurement, clears both timers, both counts, the fault flag, the filter
// pin and the first-source latch, and empties the result buffer.
module wake_line_validator import wlv_pkg::*; #(
  parameter int unsigned SAMPLES_AVERAGED = SamplesAveragedDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  logic [CfgW-1:0] ticks_q, low_q, high_q, min_rise_q;
  logic [1:0]      first_q, first_d;

  logic        accept, tick, restart, cond, in_window;
  meas_stat_t  meas;
  judge_t      judge_one, judge_two;
  logic [CountW-1:0] count_one_d, count_two_d;
  out_item_t   result;

  assign accept  = in_valid_i && in_ready_o;
  assign tick    = accept && (in_item_i.operation == OP_TICK);
  assign restart = accept && ((in_item_i.operation == OP_SLEEP_RESET) ||
                   (in_item_i.in_standby &&
                    ((in_item_i.operation == OP_DETECT_ONE) ||
                     (in_item_i.operation == OP_DETECT_TWO))));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q    <= ValidationTicksRst;
      low_q      <= BatteryLowRst;
      high_q     <= BatteryHighRst;
      min_rise_q <= CircuitMinRiseRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_VALIDATION_TICKS: ticks_q    <= cfg_data_i;
        CFG_BATTERY_LOW:      low_q      <= cfg_data_i;
        CFG_BATTERY_HIGH:     high_q     <= cfg_data_i;
        CFG_CIRCUIT_MIN_RISE: min_rise_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  wlv_measure #(
    .SAMPLES_AVERAGED(SAMPLES_AVERAGED)
  ) u_measure (
    .clk_i,
    .rst_ni,
    .tick_i    (tick),
    .restart_i (restart),
    .sample_i  (in_item_i.adc_sample),
    .min_rise_i(min_rise_q),
    .stat_o    (meas)
  );

  // The condition sees the measurement as this tick leaves it.
  assign in_window = (meas.on_level_d > LevelW'(low_q)) &&
                     (meas.on_level_d < LevelW'(high_q));
  assign cond = in_item_i.in_standby ? (meas.fault_d || in_window)
                                     : in_item_i.host_condition;

  wlv_line_judge u_judge_one (
    .clk_i,
    .rst_ni,
    .load_i   (accept && (in_item_i.operation == OP_DETECT_ONE)),
    .ticks_i  (ticks_q),
    .step_i   (tick),
    .level_i  (in_item_i.line_one_level),
    .cond_i   (cond),
    .judge_o  (judge_one),
    .count_d_o(count_one_d)
  );

  wlv_line_judge u_judge_two (
    .clk_i,
    .rst_ni,
    .load_i   (accept && (in_item_i.operation == OP_DETECT_TWO)),
    .ticks_i  (ticks_q),
    .step_i   (tick),
    .level_i  (in_item_i.line_two_level),
    .cond_i   (cond),
    .judge_o  (judge_two),
    .count_d_o(count_two_d)
  );

  // Line one has priority for the first-source latch.
  always_comb begin
    first_d = first_q;
    if (first_q == SRC_NONE) begin
      if (judge_one.confirmed) begin
        first_d = SRC_LINE_ONE;
      end else if (judge_two.confirmed) begin
        first_d = SRC_LINE_TWO;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= SRC_NONE;
    end else begin
      first_q <= first_d;
    end
  end

  always_comb begin
    result.filter_enable       = meas.filter_d;
    result.sample_taken        = meas.taken;
    result.line_one_confirmed  = judge_one.confirmed;
    result.line_two_confirmed  = judge_two.confirmed;
    result.standby_request     = judge_one.failed || judge_two.failed;
    result.circuit_fault       = meas.fault_d;
    result.first_source        = first_d;
    result.line_one_good_count = count_one_d;
    result.line_two_good_count = count_two_d;
  end

  wlv_out_buf u_out_buf (
    .clk_i,
    .rst_ni,
    .push_i (accept),
    .data_i (result),
    .ready_o(in_ready_o),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (out_item_o)
  );

  a_first_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (first_q != SRC_NONE) |=> $stable(first_q))
    else $error("first-source latch changed after being set");

  a_filter_off_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (meas.phase == PH_OFF) |-> !meas.filter_pin)
    else $error("filter enabled during filter-off averaging");

  a_stall_buffered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input blocked with no result pending");

  a_one_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick |-> !(judge_one.confirmed || judge_one.failed ||
                judge_two.confirmed || judge_two.failed || meas.taken))
    else $error("verdict or sample on a non-tick beat");

endmodule

>>> tb/tb_wake_line_validator.sv
`timescale 1ns / 1ps
// Self-checking testbench for wake_line_validator: directed corner cases, random wake sequences
// and back-to-back confirmations, all checked against an in-bench predictor. Depends on wlv_pkg
// and the RTL.
module tb_wake_line_validator;
  import wlv_pkg::*;

  localparam int unsigned Samples    = SamplesAveragedDef;
  localparam int unsigned CycleLimit = 2000000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_item_t           in_item   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_item;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx   = '0;
  logic [CfgW-1:0]    cfg_data  = '0;

  wake_line_validator uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state, mirrors the block after every accepted beat.
  phase_e              meas_phase   = PH_IDLE;
  logic [1:0]          meas_count   = '0;
  logic [LevelW-1:0]   off_sum      = '0;
  logic [LevelW-1:0]   on_sum       = '0;
  logic [TimerW-1:0]   timer_one    = '0;
  logic [TimerW-1:0]   timer_two    = '0;
  logic                fault_seen   = 1'b0;
  logic                filter_level = 1'b0;
  source_e             first_src    = SRC_NONE;
  logic [CountW-1:0]   good_one     = '0;
  logic [CountW-1:0]   good_two     = '0;
  logic [CfgW-1:0]     ticks_reg    = ValidationTicksRst;
  logic [CfgW-1:0]     low_reg      = BatteryLowRst;
  logic [CfgW-1:0]     high_reg     = BatteryHighRst;
  logic [CfgW-1:0]     rise_reg     = CircuitMinRiseRst;

  out_item_t pending_results[$];
  int        beats_sent     = 0;
  int        results_seen   = 0;
  int        confirms_seen  = 0;
  int        requests_seen  = 0;
  int        fail_count     = 0;
  int        settings_used  = 0;
  int        cycle_count    = 0;
  int        stall_left     = 0;
  logic      idle_on        = 1'b1;

  task automatic restart_measurement();
    meas_phase = PH_START;
    off_sum    = '0;
    on_sum     = '0;
  endtask

  task automatic judge_timer(inout logic [TimerW-1:0] tmr, input logic level, input logic cond,
                             input source_e src, inout logic [CountW-1:0] cnt,
                             output logic ok, output logic bad);
    ok  = 1'b0;
    bad = 1'b0;
    if (tmr != '0) begin
      if (tmr == 1) begin
        if (!level && cond) begin
          if (first_src == SRC_NONE) first_src = src;
          if (cnt != CountMax) cnt = cnt + 1'b1;
          ok = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      tmr = tmr - 1'b1;
    end
  endtask

  task automatic predict_wake_result(input in_item_t it, output out_item_t res);
    logic taken, cond, ok1, bad1, ok2, bad2;
    taken = 1'b0;
    ok1   = 1'b0;
    bad1  = 1'b0;
    ok2   = 1'b0;
    bad2  = 1'b0;
    case (it.operation) inside
      OP_DETECT_ONE, OP_DETECT_TWO: begin
        if (it.operation == OP_DETECT_ONE) timer_one = ticks_reg;
        else timer_two = ticks_reg;
        if (it.in_standby) restart_measurement();
      end
      OP_SLEEP_RESET: restart_measurement();
      default: begin
        case (meas_phase)
          PH_START: begin
            meas_count   = '0;
            filter_level = 1'b0;
            meas_phase   = PH_OFF;
          end
          PH_OFF: begin
            off_sum    = off_sum + it.adc_sample;
            meas_count = meas_count + 1'b1;
            taken      = 1'b1;
            if (meas_count >= Samples) begin
              filter_level = 1'b1;
              meas_phase   = PH_ON;
              meas_count   = '0;
              off_sum      = LevelW'(off_sum / Samples);
            end
          end
          PH_ON: begin
            on_sum     = on_sum + it.adc_sample;
            meas_count = meas_count + 1'b1;
            taken      = 1'b1;
            if (meas_count >= Samples) begin
              filter_level = 1'b0;
              meas_phase   = PH_IDLE;
              on_sum       = LevelW'(on_sum / Samples);
              fault_seen   = (int'(on_sum) - int'(off_sum)) < int'(rise_reg);
            end
          end
          default: ;
        endcase
        // In standby the window test sees on_sum as it stands, partial sums included.
        cond = it.in_standby ? (fault_seen || (on_sum > low_reg && on_sum < high_reg))
                             : it.host_condition;
        judge_timer(timer_one, it.line_one_level, cond, SRC_LINE_ONE, good_one, ok1, bad1);
        judge_timer(timer_two, it.line_two_level, cond, SRC_LINE_TWO, good_two, ok2, bad2);
      end
    endcase
    res.filter_enable       = filter_level;
    res.sample_taken        = taken;
    res.line_one_confirmed  = ok1;
    res.line_two_confirmed  = ok2;
    res.standby_request     = bad1 | bad2;
    res.circuit_fault       = fault_seen;
    res.first_source        = first_src;
    res.line_one_good_count = good_one;
    res.line_two_good_count = good_two;
  endtask

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [SampleW-1:0] sample_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return SampleW'($urandom_range(0, 255));
  endfunction

  function automatic in_item_t beat_of(op_e op, logic [SampleW-1:0] s, logic l1, logic l2,
                                       logic sb, logic hc);
    in_item_t it;
    it.operation      = op;
    it.adc_sample     = s;
    it.line_one_level = l1;
    it.line_two_level = l2;
    it.in_standby     = sb;
    it.host_condition = hc;
    return it;
  endfunction

  function automatic in_item_t random_beat();
    return beat_of(op_e'($urandom_range(0, 3)), sample_value(), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
  endfunction

  // Holds valid with a stable payload until the beat is taken, then predicts its result.
  task automatic send_beat(input in_item_t it);
    int        gap;
    out_item_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    predict_wake_result(it, res);
    pending_results.push_back(res);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_settings(input logic [CfgW-1:0] t, input logic [CfgW-1:0] l,
                                input logic [CfgW-1:0] h, input logic [CfgW-1:0] r);
    cfg_idx_e       order [4] = '{CFG_VALIDATION_TICKS, CFG_BATTERY_LOW, CFG_BATTERY_HIGH,
                                  CFG_CIRCUIT_MIN_RISE};
    logic [CfgW-1:0] vals [4];
    vals = '{t, l, h, r};
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= order[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    ticks_reg = t;
    low_reg   = l;
    high_reg  = h;
    rise_reg  = r;
    settings_used++;
  endtask

  task automatic check_field(input string name, input logic [CountW-1:0] want,
                             input logic [CountW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Result side: compares each beat with the oldest prediction and stalls at random.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat arrived with no prediction waiting");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("filter_enable", CountW'(want.filter_enable),
                    CountW'(out_item.filter_enable));
        check_field("sample_taken", CountW'(want.sample_taken),
                    CountW'(out_item.sample_taken));
        check_field("line_one_confirmed", CountW'(want.line_one_confirmed),
                    CountW'(out_item.line_one_confirmed));
        check_field("line_two_confirmed", CountW'(want.line_two_confirmed),
                    CountW'(out_item.line_two_confirmed));
        check_field("standby_request", CountW'(want.standby_request),
                    CountW'(out_item.standby_request));
        check_field("circuit_fault", CountW'(want.circuit_fault),
                    CountW'(out_item.circuit_fault));
        check_field("first_source", CountW'(want.first_source),
                    CountW'(out_item.first_source));
        check_field("line_one_good_count", want.line_one_good_count,
                    out_item.line_one_good_count);
        check_field("line_two_good_count", want.line_two_good_count,
                    out_item.line_two_good_count);
        if (want.line_one_confirmed || want.line_two_confirmed) confirms_seen++;
        if (want.standby_request) requests_seen++;
      end
    end
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2) : $urandom_range(3, 30);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Start phase, a full off/on measurement, and every input bit driven high once.
  task automatic test_measurement_cycle();
    wait_drained();
    write_settings(8'd2, 8'd60, 8'd160, 8'd20);
    send_beat(beat_of(OP_TICK, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1));
    send_beat(beat_of(OP_SLEEP_RESET, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    send_beat(beat_of(OP_TICK, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0));
    repeat (Samples) send_beat(beat_of(OP_TICK, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0));
    repeat (Samples) send_beat(beat_of(OP_TICK, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0));
  endtask

  // Confirmation in normal mode, a failure in standby, both lines on one tick, a line left high.
  task automatic test_line_judging();
    send_beat(beat_of(OP_DETECT_ONE, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1));
    repeat (2) send_beat(beat_of(OP_TICK, 8'h10, 1'b0, 1'b1, 1'b0, 1'b1));
    send_beat(beat_of(OP_DETECT_TWO, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0));
    repeat (2) send_beat(beat_of(OP_TICK, 8'h20, 1'b1, 1'b0, 1'b1, 1'b0));
    send_beat(beat_of(OP_DETECT_ONE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1));
    send_beat(beat_of(OP_DETECT_TWO, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1));
    repeat (2) send_beat(beat_of(OP_TICK, 8'h30, 1'b0, 1'b0, 1'b0, 1'b1));
    send_beat(beat_of(OP_DETECT_ONE, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1));
    repeat (2) send_beat(beat_of(OP_TICK, 8'h40, 1'b1, 1'b1, 1'b0, 1'b1));
  endtask

  // A zero tick count never reaches a judgment; an inverted window never holds.
  task automatic test_zero_ticks_and_empty_window();
    wait_drained();
    write_settings(8'd0, 8'd200, 8'd100, 8'd0);
    send_beat(beat_of(OP_DETECT_ONE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1));
    repeat (2) send_beat(beat_of(OP_TICK, 8'h55, 1'b0, 1'b0, 1'b0, 1'b1));
    wait_drained();
    write_settings(8'd1, 8'd200, 8'd100, 8'd255);
    send_beat(beat_of(OP_DETECT_TWO, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1));
    send_beat(beat_of(OP_TICK, 8'hAA, 1'b0, 1'b0, 1'b1, 1'b1));
  endtask

  // A detect burst followed by enough ticks to reach the judgment, with mostly active lines.
  task automatic send_wake_sequence();
    logic sb;
    int   which, n;
    sb    = 1'($urandom_range(0, 1));
    which = $urandom_range(0, 2);
    if (which != 1)
      send_beat(beat_of(OP_DETECT_ONE, sample_value(), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), sb, 1'($urandom_range(0, 1))));
    if (which != 0)
      send_beat(beat_of(OP_DETECT_TWO, sample_value(), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), sb, 1'($urandom_range(0, 1))));
    n = int'(ticks_reg) + int'($urandom_range(0, 3));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 3)
        send_beat(random_beat());
      else
        send_beat(beat_of(OP_TICK, sample_value(), $urandom_range(0, 99) < 20,
                          $urandom_range(0, 99) < 20,
                          ($urandom_range(0, 19) == 0) ? !sb : sb,
                          $urandom_range(0, 99) < 70));
    end
  endtask

  task automatic run_random_phase(input int beats, input logic allow_idle);
    int target;
    target = beats_sent + beats;
    while (beats_sent < target) begin
      idle_on = allow_idle && ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 99) < 78) send_wake_sequence();
      else send_beat(random_beat());
    end
    idle_on = 1'b1;
  endtask

  // Confirmations on both lines on one tick, repeated with no gaps on the input side.
  task automatic test_back_to_back_confirms();
    wait_drained();
    write_settings(8'd1, 8'd60, 8'd160, 8'd20);
    idle_on = 1'b0;
    repeat (8) begin
      send_beat(beat_of(OP_DETECT_ONE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1));
      send_beat(beat_of(OP_DETECT_TWO, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1));
      send_beat(beat_of(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1));
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_measurement_cycle();
    test_line_judging();
    test_zero_ticks_and_empty_window();

    wait_drained();
    write_settings(ValidationTicksRst, BatteryLowRst, BatteryHighRst, CircuitMinRiseRst);
    run_random_phase(180, 1'b0);
    wait_drained();
    write_settings(8'd1, 8'd0, 8'd255, 8'd0);
    run_random_phase(170, 1'b1);
    wait_drained();
    write_settings(8'd255, 8'd255, 8'd0, 8'd255);
    run_random_phase(240, 1'b1);
    wait_drained();
    write_settings(CfgW'($urandom_range(1, 12)), CfgW'($urandom_range(0, 255)),
                   CfgW'($urandom_range(0, 255)), CfgW'($urandom_range(0, 255)));
    run_random_phase(200, 1'b1);
    wait_drained();
    write_settings(8'd3, 8'd100, 8'd101, 8'd128);
    run_random_phase(120, 1'b1);

    test_back_to_back_confirms();

    wait_drained();
    repeat (5) @(posedge clk);
    $display("Sent %0d beats under %0d register settings and checked %0d results.",
             beats_sent, settings_used, results_seen);
    $display("Saw %0d confirmations and %0d standby requests, back-to-back ones included.",
             confirms_seen, requests_seen);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (pending_results.size() != 0)
        $error("%0d predicted results never arrived", pending_results.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
